FILE: rtl/mipsdec_pkg.sv
// mipsdec_pkg: types, constants and table functions of the instruction decoder
package mipsdec_pkg;

  localparam int unsigned OpW = 7;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_RSV = 2'd1,
    ST_UNS = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    K_UNS = 3'd0,
    K_RSV = 3'd1,
    K_DIR = 3'd2,
    K_SPC = 3'd3,
    K_RIM = 3'd4,
    K_MMI = 3'd5,
    K_CP0 = 3'd6,
    K_CP2 = 3'd7
  } kind_e;

  // zero-field requirement bits: rs, rt, rd, sa
  localparam logic [3:0] ZS = 4'b0001;
  localparam logic [3:0] ZT = 4'b0010;
  localparam logic [3:0] ZD = 4'b0100;
  localparam logic [3:0] ZH = 4'b1000;

  localparam logic [31:0] EretWord     = 32'h4200_0018;
  localparam logic [31:0] VcallmsMask  = 32'hffe0_003f;
  localparam logic [31:0] VcallmsVal   = 32'h4a00_0038;
  localparam logic [31:0] VcallmsrWord = 32'h4a00_d839;
  localparam logic [31:0] Cop2HiMask   = 32'hfe00_0000;
  localparam logic [31:0] Cop2HiVal    = 32'h4a00_0000;
  localparam logic [31:0] MoveMask     = 32'h0000_07fe;
  localparam logic [31:0] Cop0FnMask   = 32'h001f_ffc0;
  localparam logic [31:0] Cop0LowMask  = 32'h0000_07ff;

  localparam logic [OpW-1:0] OpEret     = 7'd109;
  localparam logic [OpW-1:0] OpVcallms  = 7'd110;
  localparam logic [OpW-1:0] OpVcallmsr = 7'd111;
  localparam logic [OpW-1:0] OpVmacro   = 7'd112;
  localparam logic [OpW-1:0] OpQmfc2    = 7'd113;
  localparam logic [OpW-1:0] OpCfc2     = 7'd114;
  localparam logic [OpW-1:0] OpQmtc2    = 7'd115;
  localparam logic [OpW-1:0] OpCtc2     = 7'd116;
  localparam logic [OpW-1:0] OpBc2f     = 7'd117;

  typedef struct packed {
    kind_e          kind;
    logic [OpW-1:0] op;
    logic [3:0]     zero;
  } entry_t;

  typedef struct packed {
    status_e        status;
    logic [OpW-1:0] op;
    logic           is_branch;
    logic           is_likely;
  } dec_t;

  function automatic entry_t de(input logic [OpW-1:0] op, input logic [3:0] z);
    de = '{kind: K_DIR, op: op, zero: z};
  endfunction

  function automatic entry_t primary_lookup(input logic [5:0] opc);
    entry_t e;
    e = '{kind: K_UNS, op: '0, zero: '0};
    case (opc)
      6'h00: e.kind = K_SPC;
      6'h01: e.kind = K_RIM;
      6'h10: e.kind = K_CP0;
      6'h12: e.kind = K_CP2;
      6'h1c: e.kind = K_MMI;
      6'h13, 6'h1d, 6'h3b: e.kind = K_RSV;
      6'h02: e = de(7'd1, 4'd0);
      6'h03: e = de(7'd2, 4'd0);
      6'h04: e = de(7'd3, 4'd0);
      6'h05: e = de(7'd4, 4'd0);
      6'h06: e = de(7'd5, ZT);
      6'h07: e = de(7'd6, ZT);
      6'h08: e = de(7'd7, 4'd0);
      6'h09: e = de(7'd8, 4'd0);
      6'h0a: e = de(7'd9, 4'd0);
      6'h0b: e = de(7'd10, 4'd0);
      6'h0c: e = de(7'd11, 4'd0);
      6'h0d: e = de(7'd12, 4'd0);
      6'h0e: e = de(7'd13, 4'd0);
      6'h0f: e = de(7'd14, ZS);
      6'h18: e = de(7'd15, 4'd0);
      6'h19: e = de(7'd16, 4'd0);
      6'h1a: e = de(7'd17, 4'd0);
      6'h1b: e = de(7'd18, 4'd0);
      6'h1e: e = de(7'd19, 4'd0);
      6'h1f: e = de(7'd20, 4'd0);
      6'h20: e = de(7'd21, 4'd0);
      6'h21: e = de(7'd22, 4'd0);
      6'h22: e = de(7'd23, 4'd0);
      6'h23: e = de(7'd24, 4'd0);
      6'h24: e = de(7'd25, 4'd0);
      6'h25: e = de(7'd26, 4'd0);
      6'h26: e = de(7'd27, 4'd0);
      6'h27: e = de(7'd28, 4'd0);
      6'h28: e = de(7'd29, 4'd0);
      6'h29: e = de(7'd30, 4'd0);
      6'h2a: e = de(7'd31, 4'd0);
      6'h2b: e = de(7'd32, 4'd0);
      6'h2c: e = de(7'd33, 4'd0);
      6'h2d: e = de(7'd34, 4'd0);
      6'h2e: e = de(7'd35, 4'd0);
      6'h37: e = de(7'd36, 4'd0);
      6'h36: e = de(7'd37, 4'd0);
      6'h3e: e = de(7'd38, 4'd0);
      6'h3f: e = de(7'd39, 4'd0);
      6'h14: e = de(7'd40, 4'd0);
      6'h15: e = de(7'd41, 4'd0);
      6'h16: e = de(7'd42, ZT);
      6'h17: e = de(7'd43, ZT);
      default: e.kind = K_UNS;
    endcase
    return e;
  endfunction

  function automatic entry_t special_lookup(input logic [5:0] fn);
    entry_t e;
    e = '{kind: K_UNS, op: '0, zero: '0};
    case (fn)
      6'h01, 6'h05, 6'h0e, 6'h15, 6'h35, 6'h37, 6'h39, 6'h3d: e.kind = K_RSV;
      6'h00: e = de(7'd44, ZS);
      6'h02: e = de(7'd45, ZS);
      6'h03: e = de(7'd46, ZS);
      6'h04: e = de(7'd47, ZH);
      6'h06: e = de(7'd48, ZH);
      6'h07: e = de(7'd49, ZH);
      6'h08: e = de(7'd50, ZT | ZD | ZH);
      6'h09: e = de(7'd51, ZT | ZH);
      6'h0c: e = de(7'd52, 4'd0);
      6'h0d: e = de(7'd53, 4'd0);
      6'h14: e = de(7'd54, ZH);
      6'h16: e = de(7'd55, ZH);
      6'h17: e = de(7'd56, ZH);
      6'h10: e = de(7'd57, ZS | ZT | ZH);
      6'h11: e = de(7'd58, ZT | ZD | ZH);
      6'h12: e = de(7'd59, ZS | ZT | ZH);
      6'h13: e = de(7'd60, ZT | ZD | ZH);
      6'h18: e = de(7'd61, ZH);
      6'h19: e = de(7'd62, ZH);
      6'h1a: e = de(7'd63, ZD | ZH);
      6'h1b: e = de(7'd64, ZD | ZH);
      6'h20: e = de(7'd65, ZH);
      6'h21: e = de(7'd66, ZH);
      6'h22: e = de(7'd67, ZH);
      6'h23: e = de(7'd68, ZH);
      6'h24: e = de(7'd69, ZH);
      6'h25: e = de(7'd70, ZH);
      6'h26: e = de(7'd71, ZH);
      6'h27: e = de(7'd72, ZH);
      6'h2a: e = de(7'd73, ZH);
      6'h2b: e = de(7'd74, ZH);
      6'h2c: e = de(7'd75, ZH);
      6'h2d: e = de(7'd76, ZH);
      6'h2e: e = de(7'd77, ZH);
      6'h2f: e = de(7'd78, ZH);
      6'h28: e = de(7'd79, ZS | ZT | ZH);
      6'h29: e = de(7'd80, ZT | ZD | ZH);
      6'h38: e = de(7'd81, ZS);
      6'h3a: e = de(7'd82, ZS);
      6'h3b: e = de(7'd83, ZS);
      6'h3c: e = de(7'd84, ZS);
      6'h3e: e = de(7'd85, ZS);
      6'h3f: e = de(7'd86, ZS);
      default: e.kind = K_UNS;
    endcase
    return e;
  endfunction

  function automatic entry_t regimm_lookup(input logic [4:0] rt);
    entry_t e;
    e = '{kind: K_UNS, op: '0, zero: '0};
    case (rt)
      5'h00: e = de(7'd87, 4'd0);
      5'h01: e = de(7'd88, 4'd0);
      5'h02: e = de(7'd89, 4'd0);
      5'h03: e = de(7'd90, 4'd0);
      5'h10: e = de(7'd91, 4'd0);
      5'h11: e = de(7'd92, 4'd0);
      5'h12: e = de(7'd93, 4'd0);
      5'h13: e = de(7'd94, 4'd0);
      5'h18: e = de(7'd95, 4'd0);
      5'h19: e = de(7'd96, 4'd0);
      default: e.kind = K_UNS;
    endcase
    return e;
  endfunction

  function automatic entry_t mmi_lookup(input logic [5:0] fn);
    entry_t e;
    e = '{kind: K_UNS, op: '0, zero: '0};
    case (fn)
      6'h00: e = de(7'd97, ZH);
      6'h01: e = de(7'd98, ZH);
      6'h10: e = de(7'd99, ZS | ZT | ZH);
      6'h11: e = de(7'd100, ZT | ZD | ZH);
      6'h12: e = de(7'd101, ZS | ZT | ZH);
      6'h13: e = de(7'd102, ZT | ZD | ZH);
      6'h18: e = de(7'd103, ZH);
      6'h19: e = de(7'd104, ZH);
      6'h1a: e = de(7'd105, ZD | ZH);
      6'h1b: e = de(7'd106, ZD | ZH);
      6'h20: e = de(7'd107, ZH);
      6'h21: e = de(7'd108, ZH);
      default: e.kind = K_UNS;
    endcase
    return e;
  endfunction

endpackage

FILE: rtl/mipsdec_core.sv
// mipsdec_core: combinational decode of one registered instruction word
module mipsdec_core (
  input  logic [31:0]           word_i,
  output mipsdec_pkg::dec_t     dec_o
);

  logic [5:0] opc, fn;
  logic [4:0] rs, rt, rd, sa;
  mipsdec_pkg::entry_t pe, se, sel;
  mipsdec_pkg::status_e st;
  logic [mipsdec_pkg::OpW-1:0] op;
  logic zbad;

  assign opc = word_i[31:26];
  assign rs  = word_i[25:21];
  assign rt  = word_i[20:16];
  assign rd  = word_i[15:11];
  assign sa  = word_i[10:6];
  assign fn  = word_i[5:0];

  // table entry selected by the primary opcode and, for SPECIAL, REGIMM and MMI, by the function or rt field
  always_comb begin
    pe = mipsdec_pkg::primary_lookup(opc);
    case (pe.kind)
      mipsdec_pkg::K_SPC: se = mipsdec_pkg::special_lookup(fn);
      mipsdec_pkg::K_RIM: se = mipsdec_pkg::regimm_lookup(rt);
      mipsdec_pkg::K_MMI: se = mipsdec_pkg::mmi_lookup(fn);
      default:            se = pe;
    endcase
    sel = se;
  end

  // required-zero field check
  assign zbad = (sel.zero[0] && rs != 5'd0) || (sel.zero[1] && rt != 5'd0) ||
                (sel.zero[2] && rd != 5'd0) || (sel.zero[3] && sa != 5'd0);

  // status and operation
  always_comb begin
    st = mipsdec_pkg::ST_UNS;
    op = '0;
    case (pe.kind)
      mipsdec_pkg::K_CP0: begin
        if (word_i == mipsdec_pkg::EretWord) begin
          st = mipsdec_pkg::ST_OK;
          op = mipsdec_pkg::OpEret;
        end else if (rs == 5'h00 || rs == 5'h04) begin
          st = ((word_i & mipsdec_pkg::Cop0LowMask) == 32'd0) ?
               mipsdec_pkg::ST_UNS : mipsdec_pkg::ST_RSV;
        end else if (rs == 5'h08) begin
          st = (rt <= 5'd3) ? mipsdec_pkg::ST_UNS : mipsdec_pkg::ST_RSV;
        end else if (rs == 5'h10 && (word_i & mipsdec_pkg::Cop0FnMask) == 32'd0 &&
                     (fn == 6'h01 || fn == 6'h02 || fn == 6'h06 || fn == 6'h08 ||
                      fn == 6'h38 || fn == 6'h39)) begin
          st = mipsdec_pkg::ST_UNS;
        end else begin
          st = mipsdec_pkg::ST_RSV;
        end
      end
      mipsdec_pkg::K_CP2: begin
        if ((word_i & mipsdec_pkg::VcallmsMask) == mipsdec_pkg::VcallmsVal) begin
          st = mipsdec_pkg::ST_OK;
          op = mipsdec_pkg::OpVcallms;
        end else if (word_i == mipsdec_pkg::VcallmsrWord) begin
          st = mipsdec_pkg::ST_OK;
          op = mipsdec_pkg::OpVcallmsr;
        end else if ((word_i & mipsdec_pkg::Cop2HiMask) == mipsdec_pkg::Cop2HiVal &&
                     (fn == 6'h28 || fn == 6'h2c || fn <= 6'h07)) begin
          st = mipsdec_pkg::ST_OK;
          op = mipsdec_pkg::OpVmacro;
        end else if ((word_i & mipsdec_pkg::Cop2HiMask) == mipsdec_pkg::Cop2HiVal &&
                     (fn == 6'h20 || fn == 6'h22 || fn == 6'h24 || fn == 6'h26)) begin
          if (rt != 5'd0) begin
            st = mipsdec_pkg::ST_RSV;
          end else begin
            st = mipsdec_pkg::ST_OK;
            op = mipsdec_pkg::OpVmacro;
          end
        end else if (rs >= 5'h10 && (fn == 6'h38 || fn == 6'h39)) begin
          st = mipsdec_pkg::ST_RSV;
        end else if (rs == 5'h01 || rs == 5'h02 || rs == 5'h05 || rs == 5'h06) begin
          if ((word_i & mipsdec_pkg::MoveMask) != 32'd0) begin
            st = mipsdec_pkg::ST_RSV;
          end else begin
            st = mipsdec_pkg::ST_OK;
            case (rs)
              5'h01:   op = mipsdec_pkg::OpQmfc2;
              5'h02:   op = mipsdec_pkg::OpCfc2;
              5'h05:   op = mipsdec_pkg::OpQmtc2;
              default: op = mipsdec_pkg::OpCtc2;
            endcase
          end
        end else if (rs == 5'h08) begin
          if (rt > 5'd3) begin
            st = mipsdec_pkg::ST_RSV;
          end else begin
            st = mipsdec_pkg::ST_OK;
            op = mipsdec_pkg::OpBc2f + {5'd0, rt[1:0]};
          end
        end else begin
          st = mipsdec_pkg::ST_UNS;
        end
      end
      default: begin
        case (sel.kind)
          mipsdec_pkg::K_RSV: st = mipsdec_pkg::ST_RSV;
          mipsdec_pkg::K_DIR: begin
            if (zbad) begin
              st = mipsdec_pkg::ST_RSV;
            end else begin
              st = mipsdec_pkg::ST_OK;
              op = (word_i == 32'd0) ? '0 : sel.op;
            end
          end
          default: st = mipsdec_pkg::ST_UNS;
        endcase
      end
    endcase
  end

  // branch flags from the operation
  always_comb begin
    dec_o.status    = st;
    dec_o.op        = op;
    dec_o.is_branch = (op >= 7'd1 && op <= 7'd6) || (op >= 7'd40 && op <= 7'd43) ||
                      op == 7'd50 || op == 7'd51 || (op >= 7'd87 && op <= 7'd94) ||
                      (op >= 7'd117 && op <= 7'd120);
    dec_o.is_likely = (op >= 7'd40 && op <= 7'd43) || op == 7'd89 || op == 7'd90 ||
                      op == 7'd93 || op == 7'd94 || op == 7'd119 || op == 7'd120;
  end

endmodule

FILE: rtl/mips_instruction_decoder.sv
// mips_instruction_decoder: top level, input register, decode and result register
// result strobe: the item passes the input register, then the result register, after the start edge that accepts it
// throughput: one item per cycle; busy is never raised
// path: input word register, table decode, result register
// reset: strobes and valid flags clear asynchronously; payload registers are not reset
// results are shown for one cycle only; the receiver cannot stall
module mips_instruction_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] instruction_word_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [6:0]  operation_code_o,
  output logic [4:0]  source_reg_o,
  output logic [4:0]  target_reg_o,
  output logic [4:0]  dest_reg_o,
  output logic [4:0]  shift_amount_o,
  output logic [5:0]  function_field_o,
  output logic [15:0] immediate_value_o,
  output logic [25:0] jump_target_o,
  output logic [14:0] vector_immediate_o,
  output logic        is_branch_o,
  output logic        is_likely_o
);

  logic in_vld_q, out_vld_q;
  logic [31:0] word_q, rword_q;
  mipsdec_pkg::dec_t dec, dec_q;

  assign busy = 1'b0;

  // valid pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= start && !busy;
      out_vld_q <= in_vld_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (start) begin
      word_q <= instruction_word_i;
    end
    if (in_vld_q) begin
      rword_q <= word_q;
      dec_q   <= dec;
    end
  end

  mipsdec_core u_core (
    .word_i (word_q),
    .dec_o  (dec)
  );

  assign done_o             = out_vld_q;
  assign status_o           = dec_q.status;
  assign operation_code_o   = dec_q.op;
  assign is_branch_o        = dec_q.is_branch;
  assign is_likely_o        = dec_q.is_likely;
  assign source_reg_o       = rword_q[25:21];
  assign target_reg_o       = rword_q[20:16];
  assign dest_reg_o         = rword_q[15:11];
  assign shift_amount_o     = rword_q[10:6];
  assign function_field_o   = rword_q[5:0];
  assign immediate_value_o  = rword_q[15:0];
  assign jump_target_o      = rword_q[25:0];
  assign vector_immediate_o = rword_q[20:6];

`ifndef SYNTHESIS
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> ##1 done_o) else $error("missing result strobe");
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, 2)) else $error("result without item");
  a_fault_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != mipsdec_pkg::ST_OK) |->
    (operation_code_o == 7'd0 && !is_branch_o))
    else $error("fault carries an operation");
  a_likely_branch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && is_likely_o) |-> is_branch_o) else $error("likely without branch");
`endif

endmodule

FILE: test/mips_instruction_decoder_test.sv
// mips_instruction_decoder_test: self-checking testbench of the instruction decoder
`timescale 1ns / 100ps

module mips_instruction_decoder_test;

  typedef struct packed {
    logic [1:0]  status;
    logic [6:0]  op;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  sa;
    logic [5:0]  fn;
    logic [15:0] imm;
    logic [25:0] target;
    logic [14:0] vimm;
    logic        branch;
    logic        likely;
  } decoded_t;

  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned RandomItems = 650;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic [31:0] word_q = '0;
  logic        busy, done;
  decoded_t    actual;

  logic [31:0] word_queue[$];
  decoded_t    decode_queue[$];
  int unsigned errors = 0;
  int unsigned words_sent = 0;
  int unsigned results_seen = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned status_count[3] = '{0, 0, 0};
  bit          stimulus_done = 1'b0;

  mips_instruction_decoder DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .instruction_word_i (word_q),
    .done_o             (done),
    .status_o           (actual.status),
    .operation_code_o   (actual.op),
    .source_reg_o       (actual.rs),
    .target_reg_o       (actual.rt),
    .dest_reg_o         (actual.rd),
    .shift_amount_o     (actual.sa),
    .function_field_o   (actual.fn),
    .immediate_value_o  (actual.imm),
    .jump_target_o      (actual.target),
    .vector_immediate_o (actual.vimm),
    .is_branch_o        (actual.branch),
    .is_likely_o        (actual.likely)
  );

  always #2 clk_i = ~clk_i;

  // own tables, written out from the instruction set
  function automatic void table_entry(input logic [5:0] opc, input logic [5:0] fn,
                                      input logic [4:0] rt,
                                      output mipsdec_pkg::kind_e kind,
                                      output logic [6:0] op, output logic [3:0] zero);
    kind = mipsdec_pkg::K_DIR;
    zero = 4'd0;
    op = 7'd0;
    case (opc)
      6'h00: begin
        case (fn)
          6'h01, 6'h05, 6'h0e, 6'h15, 6'h35, 6'h37, 6'h39, 6'h3d:
            kind = mipsdec_pkg::K_RSV;
          6'h00: begin op = 7'd44; zero = mipsdec_pkg::ZS; end
          6'h02: begin op = 7'd45; zero = mipsdec_pkg::ZS; end
          6'h03: begin op = 7'd46; zero = mipsdec_pkg::ZS; end
          6'h04: begin op = 7'd47; zero = mipsdec_pkg::ZH; end
          6'h06: begin op = 7'd48; zero = mipsdec_pkg::ZH; end
          6'h07: begin op = 7'd49; zero = mipsdec_pkg::ZH; end
          6'h08: begin
            op = 7'd50;
            zero = mipsdec_pkg::ZT | mipsdec_pkg::ZD | mipsdec_pkg::ZH;
          end
          6'h09: begin op = 7'd51; zero = mipsdec_pkg::ZT | mipsdec_pkg::ZH; end
          6'h0c: op = 7'd52;
          6'h0d: op = 7'd53;
          6'h14: begin op = 7'd54; zero = mipsdec_pkg::ZH; end
          6'h16: begin op = 7'd55; zero = mipsdec_pkg::ZH; end
          6'h17: begin op = 7'd56; zero = mipsdec_pkg::ZH; end
          6'h10: begin
            op = 7'd57;
            zero = mipsdec_pkg::ZS | mipsdec_pkg::ZT | mipsdec_pkg::ZH;
          end
          6'h11: begin
            op = 7'd58;
            zero = mipsdec_pkg::ZT | mipsdec_pkg::ZD | mipsdec_pkg::ZH;
          end
          6'h12: begin
            op = 7'd59;
            zero = mipsdec_pkg::ZS | mipsdec_pkg::ZT | mipsdec_pkg::ZH;
          end
          6'h13: begin
            op = 7'd60;
            zero = mipsdec_pkg::ZT | mipsdec_pkg::ZD | mipsdec_pkg::ZH;
          end
          6'h18: begin op = 7'd61; zero = mipsdec_pkg::ZH; end
          6'h19: begin op = 7'd62; zero = mipsdec_pkg::ZH; end
          6'h1a: begin op = 7'd63; zero = mipsdec_pkg::ZD | mipsdec_pkg::ZH; end
          6'h1b: begin op = 7'd64; zero = mipsdec_pkg::ZD | mipsdec_pkg::ZH; end
          6'h20, 6'h21, 6'h22, 6'h23, 6'h24, 6'h25, 6'h26, 6'h27: begin
            op = 7'd65 + fn - 6'h20; zero = mipsdec_pkg::ZH;
          end
          6'h2a, 6'h2b, 6'h2c, 6'h2d, 6'h2e, 6'h2f: begin
            op = 7'd73 + fn - 6'h2a; zero = mipsdec_pkg::ZH;
          end
          6'h28: begin
            op = 7'd79;
            zero = mipsdec_pkg::ZS | mipsdec_pkg::ZT | mipsdec_pkg::ZH;
          end
          6'h29: begin
            op = 7'd80;
            zero = mipsdec_pkg::ZT | mipsdec_pkg::ZD | mipsdec_pkg::ZH;
          end
          6'h38: begin op = 7'd81; zero = mipsdec_pkg::ZS; end
          6'h3a, 6'h3b, 6'h3c: begin
            op = 7'd82 + fn - 6'h3a; zero = mipsdec_pkg::ZS;
          end
          6'h3e, 6'h3f: begin op = 7'd85 + fn - 6'h3e; zero = mipsdec_pkg::ZS; end
          default: kind = mipsdec_pkg::K_UNS;
        endcase
      end
      6'h01: begin
        case (rt)
          5'h00, 5'h01, 5'h02, 5'h03: op = 7'd87 + rt;
          5'h10, 5'h11, 5'h12, 5'h13: op = 7'd91 + rt - 5'h10;
          5'h18, 5'h19: op = 7'd95 + rt - 5'h18;
          default: kind = mipsdec_pkg::K_UNS;
        endcase
      end
      6'h1c: begin
        case (fn)
          6'h00: begin op = 7'd97; zero = mipsdec_pkg::ZH; end
          6'h01: begin op = 7'd98; zero = mipsdec_pkg::ZH; end
          6'h10: begin
            op = 7'd99;
            zero = mipsdec_pkg::ZS | mipsdec_pkg::ZT | mipsdec_pkg::ZH;
          end
          6'h11: begin
            op = 7'd100;
            zero = mipsdec_pkg::ZT | mipsdec_pkg::ZD | mipsdec_pkg::ZH;
          end
          6'h12: begin
            op = 7'd101;
            zero = mipsdec_pkg::ZS | mipsdec_pkg::ZT | mipsdec_pkg::ZH;
          end
          6'h13: begin
            op = 7'd102;
            zero = mipsdec_pkg::ZT | mipsdec_pkg::ZD | mipsdec_pkg::ZH;
          end
          6'h18: begin op = 7'd103; zero = mipsdec_pkg::ZH; end
          6'h19: begin op = 7'd104; zero = mipsdec_pkg::ZH; end
          6'h1a: begin op = 7'd105; zero = mipsdec_pkg::ZD | mipsdec_pkg::ZH; end
          6'h1b: begin op = 7'd106; zero = mipsdec_pkg::ZD | mipsdec_pkg::ZH; end
          6'h20: begin op = 7'd107; zero = mipsdec_pkg::ZH; end
          6'h21: begin op = 7'd108; zero = mipsdec_pkg::ZH; end
          default: kind = mipsdec_pkg::K_UNS;
        endcase
      end
      6'h13, 6'h1d, 6'h3b: kind = mipsdec_pkg::K_RSV;
      6'h02, 6'h03, 6'h04, 6'h05: op = 7'd1 + opc - 6'h02;
      6'h06, 6'h07: begin op = 7'd5 + opc - 6'h06; zero = mipsdec_pkg::ZT; end
      6'h08, 6'h09, 6'h0a, 6'h0b, 6'h0c, 6'h0d, 6'h0e: op = 7'd7 + opc - 6'h08;
      6'h0f: begin op = 7'd14; zero = mipsdec_pkg::ZS; end
      6'h18, 6'h19, 6'h1a, 6'h1b: op = 7'd15 + opc - 6'h18;
      6'h1e, 6'h1f: op = 7'd19 + opc - 6'h1e;
      6'h20, 6'h21, 6'h22, 6'h23, 6'h24, 6'h25, 6'h26, 6'h27,
      6'h28, 6'h29, 6'h2a, 6'h2b, 6'h2c, 6'h2d, 6'h2e: op = 7'd21 + opc - 6'h20;
      6'h37: op = 7'd36;
      6'h36: op = 7'd37;
      6'h3e, 6'h3f: op = 7'd38 + opc - 6'h3e;
      6'h14, 6'h15: op = 7'd40 + opc - 6'h14;
      6'h16, 6'h17: begin op = 7'd42 + opc - 6'h16; zero = mipsdec_pkg::ZT; end
      default: kind = mipsdec_pkg::K_UNS;
    endcase
  endfunction

  // expected result for one instruction word
  function automatic decoded_t decode_word(input logic [31:0] w);
    decoded_t             d;
    mipsdec_pkg::kind_e   kind;
    logic [6:0]           op;
    logic [3:0]           zero;
    logic [31:0]          mask;
    mipsdec_pkg::status_e st;
    logic [5:0]           opc, fn;
    logic [4:0]           rs, rt;
    opc = w[31:26];
    rs = w[25:21];
    rt = w[20:16];
    fn = w[5:0];
    st = mipsdec_pkg::ST_OK;
    op = 7'd0;
    if (opc == 6'h10) begin
      // coprocessor zero rules
      if (w == 32'h4200_0018) op = 7'd109;
      else if (rs == 5'd0 || rs == 5'd4)
        st = (w[10:0] == 0) ? mipsdec_pkg::ST_UNS : mipsdec_pkg::ST_RSV;
      else if (rs == 5'd8) st = (rt <= 5'd3) ? mipsdec_pkg::ST_UNS : mipsdec_pkg::ST_RSV;
      else if (rs == 5'd16 && w[20:6] == 0 &&
               (fn == 6'h01 || fn == 6'h02 || fn == 6'h06 || fn == 6'h08 ||
                fn == 6'h38 || fn == 6'h39)) st = mipsdec_pkg::ST_UNS;
      else st = mipsdec_pkg::ST_RSV;
    end else if (opc == 6'h12) begin
      // coprocessor two rules, in priority order
      if (w[31:21] == 11'h250 && fn == 6'h38) op = 7'd110;
      else if (w == 32'h4a00_d839) op = 7'd111;
      else if (w[31:25] == 7'b0100101 && (fn == 6'h28 || fn == 6'h2c || fn <= 6'h07))
        op = 7'd112;
      else if (w[31:25] == 7'b0100101 &&
               (fn == 6'h20 || fn == 6'h22 || fn == 6'h24 || fn == 6'h26)) begin
        if (rt != 0) st = mipsdec_pkg::ST_RSV;
        else op = 7'd112;
      end else if (rs >= 5'd16 && (fn == 6'h38 || fn == 6'h39)) st = mipsdec_pkg::ST_RSV;
      else if (rs == 5'd1 || rs == 5'd2 || rs == 5'd5 || rs == 5'd6) begin
        if (w[10:1] != 0) st = mipsdec_pkg::ST_RSV;
        else op = (rs == 5'd1) ? 7'd113 : (rs == 5'd2) ? 7'd114 :
                  (rs == 5'd5) ? 7'd115 : 7'd116;
      end else if (rs == 5'd8) begin
        if (rt > 5'd3) st = mipsdec_pkg::ST_RSV;
        else op = 7'd117 + rt;
      end else st = mipsdec_pkg::ST_UNS;
    end else begin
      table_entry(opc, fn, rt, kind, op, zero);
      mask = '0;
      if (zero[0]) mask |= 32'h03e0_0000;
      if (zero[1]) mask |= 32'h001f_0000;
      if (zero[2]) mask |= 32'h0000_f800;
      if (zero[3]) mask |= 32'h0000_07c0;
      if (kind == mipsdec_pkg::K_RSV) st = mipsdec_pkg::ST_RSV;
      else if (kind != mipsdec_pkg::K_DIR) st = mipsdec_pkg::ST_UNS;
      else if ((w & mask) != 0) st = mipsdec_pkg::ST_RSV;
      if (w == 0) op = 7'd0;
    end
    if (st != mipsdec_pkg::ST_OK) op = 7'd0;
    d.status = st;
    d.op = op;
    d.rs = rs;
    d.rt = rt;
    d.rd = w[15:11];
    d.sa = w[10:6];
    d.fn = fn;
    d.imm = w[15:0];
    d.target = w[25:0];
    d.vimm = w[20:6];
    d.branch = (op >= 1 && op <= 6) || (op >= 40 && op <= 43) || op == 50 ||
               op == 51 || (op >= 87 && op <= 94) || (op >= 117 && op <= 120);
    d.likely = (op >= 40 && op <= 43) || op == 89 || op == 90 || op == 93 ||
               op == 94 || op == 119 || op == 120;
    return d;
  endfunction

  // random word: mostly legal-looking encodings, some pure noise
  function automatic logic [31:0] random_word();
    logic [31:0] w;
    int unsigned sel;
    w = $urandom;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1: if ($urandom_range(0, 1)) w[10:6] = 5'd0;
      2: begin w[31:26] = 6'h00; if ($urandom_range(0, 1)) w[10:6] = 5'd0; end
      3: begin
        w[31:26] = 6'h01;
        w[20:16] = $urandom_range(0, 1) ? 5'(5'h10 + $urandom_range(0, 3))
                                        : 5'($urandom_range(0, 3));
      end
      4: begin w[31:26] = 6'h1c; if ($urandom_range(0, 1)) w[10:6] = 5'd0; end
      5: begin w[31:26] = 6'h10; w[25:21] = 5'(4 * $urandom_range(0, 4));
               if ($urandom_range(0, 1)) w[20:6] = '0; end
      6, 7: begin w[31:26] = 6'h12;
               if ($urandom_range(0, 1)) w[10:1] = '0;
               if ($urandom_range(0, 2) == 0) w[25:21] = 5'd8;
               if ($urandom_range(0, 2) == 0) w[20:16] = 5'($urandom_range(0, 3)); end
      default: ;
    endcase
    return w;
  endfunction

  // stimulus: directed words first, then random ones
  initial begin
    logic [31:0] directed[$];
    directed = '{32'h0000_0000, 32'hffff_ffff, 32'h4200_0018, 32'h4a00_0038,
                 32'h4bff_ffb8, 32'h4a00_d839, 32'h4a00_0028, 32'h4a01_0020,
                 32'h4a00_0022, 32'h4b00_0038, 32'h4840_0000, 32'h4840_0002,
                 32'h4903_0000, 32'h4904_0000, 32'h4800_0000, 32'h4000_0000,
                 32'h4000_0001, 32'h4100_0000, 32'h4200_0001, 32'h4220_0001,
                 32'h0800_0000, 32'h5800_0000, 32'h5801_0000, 32'h0000_0008,
                 32'h7000_0021};
    foreach (directed[i]) word_queue.push_back(directed[i]);
    // sweep every primary and function slot once
    for (int i = 0; i < 64; i++) begin
      word_queue.push_back({i[5:0], 26'd0});
      word_queue.push_back({6'h00, 20'd0, i[5:0]});
      word_queue.push_back({6'h1c, 20'd0, i[5:0]});
    end
    for (int i = 0; i < 32; i++) word_queue.push_back({6'h01, 5'd0, i[4:0], 16'd0});
    for (int i = 0; i < RandomItems; i++) word_queue.push_back(random_word());
  end

  // driver: bursts of random length, some of them separated by random gaps
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        decode_queue.push_back(decode_word(word_q));
        words_sent++;
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (word_queue.size() > 0) begin
          word_q <= word_queue.pop_front();
          start <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
          end else begin
            burst_left--;
            if (burst_left == 0 && $urandom_range(0, 1)) gap_left = $urandom_range(1, 6);
          end
        end else begin
          start <= 1'b0;
          stimulus_done = 1'b1;
        end
      end
    end
  end

  // monitor: compare every result with the oldest expectation
  always @(posedge clk_i) begin
    decoded_t want;
    if (rst_ni && done) begin
      results_seen++;
      if (decode_queue.size() == 0) begin
        errors++;
        $display("%0t: result with no item pending, actual %p", $time, actual);
      end else begin
        want = decode_queue.pop_front();
        if (want.status < 3) status_count[want.status]++;
        if (want !== actual) begin
          errors++;
          $display("%0t: mismatch, expected %p, actual %p", $time, want, actual);
        end
      end
    end
  end

  // watchdog on cycles with no progress
  always @(posedge clk_i) begin
    if ((start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (!(stimulus_done && decode_queue.size() == 0) && idle_cycles < IdleLimit)
      @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (idle_cycles >= IdleLimit) begin
      $display("mips_instruction_decoder_test: done, errors");
    end else begin
      $display("decoded %0d words, %0d results: %0d ok, %0d reserved, %0d unsupported",
               words_sent, results_seen, status_count[0], status_count[1], status_count[2]);
      if (errors == 0 && decode_queue.size() == 0) begin
        $display("mips_instruction_decoder_test: done, clean");
      end else begin
        $display("mips_instruction_decoder_test: done, errors");
      end
    end
    $finish;
  end

endmodule
